[rtl/core/msp_frame_deframer_assert.svh]
// ----------------------------------------------------------------------------
// msp_frame_deframer_assert.svh
// Assertion macros for the MSP frame deframer.
// ----------------------------------------------------------------------------
`ifndef MSP_FRAME_DEFRAMER_ASSERT_SVH
`define MSP_FRAME_DEFRAMER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define MSPD_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("msp_frame_deframer: assertion failed");

// Antecedent implies consequent in the next cycle.
`define MSPD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("msp_frame_deframer: assertion failed");

`endif

[rtl/core/mspd_pkg.sv]
// ----------------------------------------------------------------------------
// mspd_pkg
// Types, constants and the CRC-8/DVB-S2 step for the MSP frame deframer.
// ----------------------------------------------------------------------------
package mspd_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4d;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_BANG   = 8'h21;

    localparam logic [7:0] CRC_POLY  = 8'hd5;

    localparam logic [1:0] DIR_TO_FC   = 2'd0;
    localparam logic [1:0] DIR_FROM_FC = 2'd1;
    localparam logic [1:0] DIR_ERROR   = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_HDR_M    = 4'd1,
        PH_HDR_DIR  = 4'd2,
        PH_V1_SIZE  = 4'd3,
        PH_V1_CMD   = 4'd4,
        PH_V1_PAY   = 4'd5,
        PH_V1_CK    = 4'd6,
        PH_V2_FLAGS = 4'd7,
        PH_V2_FLO   = 4'd8,
        PH_V2_FHI   = 4'd9,
        PH_V2_SLO   = 4'd10,
        PH_V2_SHI   = 4'd11,
        PH_V2_PAY   = 4'd12,
        PH_V2_CK    = 4'd13
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BAD     = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [7:0]   data;
        logic [9:0]   index;
        logic [15:0]  func;
        logic [10:0]  size;
        logic         v2;
        logic [1:0]   dir;
        logic [31:0]  good;
        logic [31:0]  bad;
    } evt_t;

    typedef struct packed {
        logic valid;
        evt_t evt;
    } result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/mspd_byte_if.sv]
// ----------------------------------------------------------------------------
// mspd_byte_if
// Byte channel into the deframer: one received byte per beat.
// ----------------------------------------------------------------------------
interface mspd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/core/mspd_event_if.sv]
// ----------------------------------------------------------------------------
// mspd_event_if
// Event channel out of the deframer: one payload byte or verdict per beat.
// ----------------------------------------------------------------------------
interface mspd_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  payload_data;
    logic [9:0]  payload_index;
    logic [15:0] function_code;
    logic [10:0] frame_size;
    logic        is_version_two;
    logic [1:0]  direction;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;

    modport source (
        output valid, output event_kind, output payload_data, output payload_index,
        output function_code, output frame_size, output is_version_two,
        output direction, output good_frames, output bad_frames,
        input ready
    );
    modport sink (
        input valid, input event_kind, input payload_data, input payload_index,
        input function_code, input frame_size, input is_version_two,
        input direction, input good_frames, input bad_frames,
        output ready
    );
endinterface

[rtl/core/msp_frame_deframer.sv]
// ----------------------------------------------------------------------------
// msp_frame_deframer
// Streaming MSP v1/v2 deframer: payload bytes and checksum verdicts out.
// ----------------------------------------------------------------------------
// One received byte is taken per beat, every cycle the output buffer has
// room, and is parsed in the same cycle by the frame state machine; any
// event it causes (a payload byte, or a good/bad verdict carrying the
// running frame counts) is registered into a two-entry output buffer and
// is presented on the event channel from the buffer's head entry. Header,
// direction, size, function and flags bytes produce no event, nor does a v2
// frame whose declared size exceeds MAX_PAYLOAD. The byte channel stalls
// only while both output entries are full, so throughput is one byte per
// cycle for as long as the sink keeps up.
// ----------------------------------------------------------------------------
`include "msp_frame_deframer_assert.svh"

module msp_frame_deframer #(
    parameter int MAX_PAYLOAD = mspd_pkg::MAX_PAYLOAD_DEF
) (
    input logic           clk,
    input logic           rst_n,
    mspd_byte_if.sink     rx,
    mspd_event_if.source  ev
);

    mspd_pkg::result_t res;
    mspd_pkg::evt_t    head;
    logic              can_push;
    logic              ev_verdict;
    logic              ev_zero;
    logic              ev_kind_ok;

    assign rx.ready = can_push;

    mspd_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (rx.valid && can_push),
        .rx_byte    (rx.rx_byte),
        .res        (res)
    );

    mspd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res),
        .can_push  (can_push),
        .out_valid (ev.valid),
        .out_ready (ev.ready),
        .out_evt   (head)
    );

    assign ev.event_kind     = head.kind;
    assign ev.payload_data   = head.data;
    assign ev.payload_index  = head.index;
    assign ev.function_code  = head.func;
    assign ev.frame_size     = head.size;
    assign ev.is_version_two = head.v2;
    assign ev.direction      = head.dir;
    assign ev.good_frames    = head.good;
    assign ev.bad_frames     = head.bad;

    assign ev_verdict = ev.event_kind != mspd_pkg::EV_PAYLOAD;
    assign ev_zero    = ev.payload_data == 8'd0 && ev.payload_index == 10'd0;
    assign ev_kind_ok = ev.event_kind == mspd_pkg::EV_PAYLOAD
                        || ev.event_kind == mspd_pkg::EV_GOOD
                        || ev.event_kind == mspd_pkg::EV_BAD;

    `MSPD_ASSERT_IMPL(a_verdict_zero, clk, rst_n, ev.valid && ev_verdict, ev_zero)
    `MSPD_ASSERT_IMPL(a_kind_legal, clk, rst_n, ev.valid, ev_kind_ok)
    `MSPD_ASSERT_IMPL(a_v1_size, clk, rst_n, ev.valid && !ev.is_version_two, ev.frame_size <= 11'd255)
    `MSPD_ASSERT_NEXT(a_full_holds, clk, rst_n, !rx.ready && !(ev.valid && ev.ready), !rx.ready)

endmodule

[rtl/core/mspd_parser.sv]
// ----------------------------------------------------------------------------
// mspd_parser
// Frame state machine: header hunt, v1 XOR check, v2 CRC-8, payload streaming
// and good/bad frame counters. One byte is consumed per beat.
// ----------------------------------------------------------------------------
module mspd_parser #(
    parameter int MAX_PAYLOAD = mspd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        rx_byte,
    output mspd_pkg::result_t res
);

    localparam int SIZE_W = $clog2(MAX_PAYLOAD + 1);

    mspd_pkg::phase_t phase_reg, phase_next;
    logic              v2_reg, v2_next;
    logic [1:0]        dir_reg, dir_next;
    logic [7:0]        check_reg, check_next;
    logic [15:0]       func_reg, func_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [10:0]       seen_reg, seen_next;
    logic [31:0]       good_reg, good_next;
    logic [31:0]       bad_reg, bad_next;

    logic [15:0] size_ext;
    logic [15:0] size_full;
    logic [10:0] seen_inc;
    logic        seen_done;
    logic        oversize;
    logic [7:0]  crc_in;
    logic        dir_ok;
    logic [1:0]  dir_code;

    assign size_ext  = 16'(size_reg);
    assign size_full = {rx_byte, size_ext[7:0]};
    assign seen_inc  = seen_reg + 11'd1;
    assign seen_done = 16'(seen_inc) >= size_ext;
    assign oversize  = size_full > 16'(MAX_PAYLOAD);
    assign crc_in    = mspd_pkg::crc8_step(check_reg, rx_byte);

    always_comb
    begin
        dir_ok   = 1'b1;
        dir_code = mspd_pkg::DIR_TO_FC;
        unique case (rx_byte)
            mspd_pkg::CH_LT:   dir_code = mspd_pkg::DIR_TO_FC;
            mspd_pkg::CH_GT:   dir_code = mspd_pkg::DIR_FROM_FC;
            mspd_pkg::CH_BANG: dir_code = mspd_pkg::DIR_ERROR;
            default:           dir_ok   = 1'b0;
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                mspd_pkg::PH_HDR_M:
                begin
                    if (rx_byte == mspd_pkg::CH_M || rx_byte == mspd_pkg::CH_X)
                    begin
                        phase_next = mspd_pkg::PH_HDR_DIR;
                    end
                    else if (rx_byte != mspd_pkg::CH_DOLLAR)
                    begin
                        phase_next = mspd_pkg::PH_IDLE;
                    end
                end
                mspd_pkg::PH_HDR_DIR:
                begin
                    if (!dir_ok)
                    begin
                        phase_next = mspd_pkg::PH_IDLE;
                    end
                    else if (v2_reg)
                    begin
                        phase_next = mspd_pkg::PH_V2_FLAGS;
                    end
                    else
                    begin
                        phase_next = mspd_pkg::PH_V1_SIZE;
                    end
                end
                mspd_pkg::PH_V1_SIZE:  phase_next = mspd_pkg::PH_V1_CMD;
                mspd_pkg::PH_V1_CMD:
                begin
                    phase_next = (size_reg != '0) ? mspd_pkg::PH_V1_PAY : mspd_pkg::PH_V1_CK;
                end
                mspd_pkg::PH_V1_PAY:
                begin
                    if (seen_done)
                    begin
                        phase_next = mspd_pkg::PH_V1_CK;
                    end
                end
                mspd_pkg::PH_V2_PAY:
                begin
                    if (seen_done)
                    begin
                        phase_next = mspd_pkg::PH_V2_CK;
                    end
                end
                mspd_pkg::PH_V1_CK,
                mspd_pkg::PH_V2_CK:    phase_next = mspd_pkg::PH_IDLE;
                mspd_pkg::PH_V2_FLAGS: phase_next = mspd_pkg::PH_V2_FLO;
                mspd_pkg::PH_V2_FLO:   phase_next = mspd_pkg::PH_V2_FHI;
                mspd_pkg::PH_V2_FHI:   phase_next = mspd_pkg::PH_V2_SLO;
                mspd_pkg::PH_V2_SLO:   phase_next = mspd_pkg::PH_V2_SHI;
                mspd_pkg::PH_V2_SHI:
                begin
                    if (oversize)
                    begin
                        phase_next = mspd_pkg::PH_IDLE;
                    end
                    else if (size_full != 16'd0)
                    begin
                        phase_next = mspd_pkg::PH_V2_PAY;
                    end
                    else
                    begin
                        phase_next = mspd_pkg::PH_V2_CK;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == mspd_pkg::CH_DOLLAR) ? mspd_pkg::PH_HDR_M
                                                                  : mspd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Frame fields, check and result
    always_comb
    begin
        v2_next    = v2_reg;
        dir_next   = dir_reg;
        check_next = check_reg;
        func_next  = func_reg;
        size_next  = size_reg;
        seen_next  = seen_reg;
        good_next  = good_reg;
        bad_next   = bad_reg;
        res.valid  = 1'b0;
        res.evt.kind = mspd_pkg::EV_PAYLOAD;
        res.evt.data = 8'd0;
        res.evt.index = 10'd0;
        if (byte_valid)
        begin
            unique case (phase_reg)
                mspd_pkg::PH_HDR_M:
                begin
                    if (rx_byte == mspd_pkg::CH_M)
                    begin
                        v2_next = 1'b0;
                    end
                    else if (rx_byte == mspd_pkg::CH_X)
                    begin
                        v2_next = 1'b1;
                    end
                end
                mspd_pkg::PH_HDR_DIR:
                begin
                    if (dir_ok)
                    begin
                        dir_next   = dir_code;
                        seen_next  = 11'd0;
                        check_next = 8'd0;
                    end
                end
                mspd_pkg::PH_V1_SIZE:
                begin
                    size_next  = SIZE_W'(rx_byte);
                    check_next = rx_byte;
                end
                mspd_pkg::PH_V1_CMD:
                begin
                    func_next  = {8'h00, rx_byte};
                    check_next = check_reg ^ rx_byte;
                end
                mspd_pkg::PH_V1_PAY,
                mspd_pkg::PH_V2_PAY:
                begin
                    check_next = (phase_reg == mspd_pkg::PH_V1_PAY) ? (check_reg ^ rx_byte)
                                                                    : crc_in;
                    seen_next     = seen_inc;
                    res.valid     = 1'b1;
                    res.evt.kind  = mspd_pkg::EV_PAYLOAD;
                    res.evt.data  = rx_byte;
                    res.evt.index = seen_reg[9:0];
                end
                mspd_pkg::PH_V1_CK,
                mspd_pkg::PH_V2_CK:
                begin
                    res.valid = 1'b1;
                    if (check_reg == rx_byte)
                    begin
                        good_next    = good_reg + 32'd1;
                        res.evt.kind = mspd_pkg::EV_GOOD;
                    end
                    else
                    begin
                        bad_next     = bad_reg + 32'd1;
                        res.evt.kind = mspd_pkg::EV_BAD;
                    end
                end
                mspd_pkg::PH_V2_FLAGS:
                begin
                    check_next = mspd_pkg::crc8_step(8'd0, rx_byte);
                end
                mspd_pkg::PH_V2_FLO:
                begin
                    func_next  = {8'h00, rx_byte};
                    check_next = crc_in;
                end
                mspd_pkg::PH_V2_FHI:
                begin
                    func_next  = {rx_byte, func_reg[7:0]};
                    check_next = crc_in;
                end
                mspd_pkg::PH_V2_SLO:
                begin
                    size_next  = SIZE_W'(rx_byte);
                    check_next = crc_in;
                end
                mspd_pkg::PH_V2_SHI:
                begin
                    size_next  = SIZE_W'(size_full);
                    check_next = crc_in;
                end
                default:
                begin
                    v2_next = v2_reg;
                end
            endcase
        end
        res.evt.func = func_next;
        res.evt.size = size_ext[10:0];
        res.evt.v2   = v2_reg;
        res.evt.dir  = dir_reg;
        res.evt.good = good_next;
        res.evt.bad  = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mspd_pkg::PH_IDLE;
            v2_reg    <= 1'b0;
            dir_reg   <= 2'd0;
            check_reg <= 8'd0;
            func_reg  <= 16'd0;
            size_reg  <= '0;
            seen_reg  <= 11'd0;
            good_reg  <= 32'd0;
            bad_reg   <= 32'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            v2_reg    <= v2_next;
            dir_reg   <= dir_next;
            check_reg <= check_next;
            func_reg  <= func_next;
            size_reg  <= size_next;
            seen_reg  <= seen_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

[rtl/core/mspd_out_buf.sv]
// ----------------------------------------------------------------------------
// mspd_out_buf
// Two-entry result register with skid slot: takes a new event while the
// previous one waits for the sink.
// ----------------------------------------------------------------------------
module mspd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  mspd_pkg::result_t push,
    output logic              can_push,
    output logic              out_valid,
    input  logic              out_ready,
    output mspd_pkg::evt_t    out_evt
);

    logic [1:0]     count_reg, count_next;
    mspd_pkg::evt_t head_reg, head_next;
    mspd_pkg::evt_t tail_reg, tail_next;
    logic           pop;

    assign can_push  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_evt   = head_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        case ({push.valid, pop})
            2'b10:
            begin
                count_next = count_reg + 2'd1;
                if (count_reg == 2'd0)
                begin
                    head_next = push.evt;
                end
                else
                begin
                    tail_next = push.evt;
                end
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = push.evt;
                end
                else
                begin
                    head_next = tail_reg;
                    tail_next = push.evt;
                end
            end
            2'b01:
            begin
                count_next = count_reg - 2'd1;
                head_next  = tail_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
